[rtl/anchor_table_line_mapper_core_defines.svh]
// Assertion macros for the anchor table line mapper
`ifndef ANCHOR_TABLE_LINE_MAPPER_CORE_DEFINES_SVH
`define ANCHOR_TABLE_LINE_MAPPER_CORE_DEFINES_SVH

// same-cycle implication
`define ATLM_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("atlm: implication check failed");

// next-cycle implication
`define ATLM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("atlm: next-cycle check failed");

`endif

[rtl/atlm_pkg.sv]
// Shared types and constants for the anchor table line mapper
`timescale 1ns / 1ps
package atlm_pkg;

  localparam int MAX_ANCHORS_DEF = 64;
  localparam int LINE_BITS_DEF   = 20;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_MAP_RL = 2'd2,
    ACT_MAP_LR = 2'd3
  } action_t;

  // control part of the lookup word walking the cell chain
  typedef struct packed {
    logic valid;
    logic dir;    // 1: key is left side
    logic found;
    logic pass;   // hit on the first anchor
  } tok_ctl_t;

endpackage

[rtl/anchor_table_line_mapper_core.sv]
// Anchor table line mapper: anchor cell chain, multiplier stage and divider
// Clear and append: one word per cycle, busy stays low. A map holds busy until its
// result strobes, so the next word is taken on the edge that takes the result. A
// map that is passed through strobes out of the cell chain; any other map goes on
// through the cell chain, one multiply and LINE_BITS divide steps.
// Synchronous reset empties the table and idles the block; no result is pending.
`timescale 1ns / 1ps
module anchor_table_line_mapper_core
  import atlm_pkg::*;
#(
  parameter int MAX_ANCHORS = MAX_ANCHORS_DEF,
  parameter int LINE_BITS   = LINE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           action,
  input  logic [LINE_BITS-1:0] left_line,
  input  logic [LINE_BITS-1:0] right_line,
  input  logic [LINE_BITS-1:0] query_pos,
  output logic                 done,
  output logic [LINE_BITS-1:0] mapped_pos
);

  localparam int CNT_W = $clog2(MAX_ANCHORS + 1);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_MUL, S_DIV} state_t;

  state_t                 state;
  logic [CNT_W-1:0]       count;
  logic                   accept;
  logic                   app_en;
  logic [LINE_BITS-1:0]   q_d;
  logic [LINE_BITS-1:0]   den;
  logic [LINE_BITS-1:0]   olo;
  logic [LINE_BITS-1:0]   mag;
  logic                   neg;
  logic [2*LINE_BITS-1:0] prod;
  logic                   div_go;
  logic                   div_done;
  logic [LINE_BITS-1:0]   div_quo;

  tok_ctl_t             ctl_c    [0:MAX_ANCHORS];
  logic [LINE_BITS-1:0] q_c      [0:MAX_ANCHORS];
  logic [LINE_BITS-1:0] lo_key_c [0:MAX_ANCHORS];
  logic [LINE_BITS-1:0] lo_oth_c [0:MAX_ANCHORS];
  logic [LINE_BITS-1:0] hi_key_c [0:MAX_ANCHORS];
  logic [LINE_BITS-1:0] hi_oth_c [0:MAX_ANCHORS];

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign app_en = accept && (action_t'(action) == ACT_APPEND)
                  && (count < CNT_W'(MAX_ANCHORS));

  always_comb begin
    ctl_c[0].valid = accept && ((action_t'(action) == ACT_MAP_RL)
                                || (action_t'(action) == ACT_MAP_LR));
    ctl_c[0].dir   = (action_t'(action) == ACT_MAP_LR);
    ctl_c[0].found = 1'b0;
    ctl_c[0].pass  = 1'b0;
  end
  assign q_c[0]      = query_pos;
  assign lo_key_c[0] = '0;
  assign lo_oth_c[0] = '0;
  assign hi_key_c[0] = '0;
  assign hi_oth_c[0] = '0;

  for (genvar i = 0; i < MAX_ANCHORS; i++) begin : g_cell
    atlm_cell #(
      .LINE_BITS (LINE_BITS),
      .CNT_W     (CNT_W),
      .IDX       (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .app_en     (app_en),
      .count      (count),
      .new_left   (left_line),
      .new_right  (right_line),
      .ctl_in     (ctl_c[i]),
      .q_in       (q_c[i]),
      .lo_key_in  (lo_key_c[i]),
      .lo_oth_in  (lo_oth_c[i]),
      .hi_key_in  (hi_key_c[i]),
      .hi_oth_in  (hi_oth_c[i]),
      .ctl_out    (ctl_c[i+1]),
      .q_out      (q_c[i+1]),
      .lo_key_out (lo_key_c[i+1]),
      .lo_oth_out (lo_oth_c[i+1]),
      .hi_key_out (hi_key_c[i+1]),
      .hi_oth_out (hi_oth_c[i+1])
    );
  end

  atlm_div #(
    .LINE_BITS (LINE_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (prod),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      done   <= 1'b0;
      div_go <= 1'b0;
    end else begin
      done   <= 1'b0;
      div_go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (action_t'(action))
              ACT_CLEAR:  count <= '0;
              ACT_APPEND: begin
                if (app_en) count <= count + CNT_W'(1);
              end
              ACT_MAP_RL, ACT_MAP_LR: state <= S_WALK;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_WALK: begin
          if (ctl_c[MAX_ANCHORS].valid) begin
            if (!ctl_c[MAX_ANCHORS].found || ctl_c[MAX_ANCHORS].pass) begin
              mapped_pos <= q_c[MAX_ANCHORS];
              done       <= 1'b1;
              state      <= S_IDLE;
            end else begin
              q_d   <= q_c[MAX_ANCHORS] - lo_key_c[MAX_ANCHORS];
              den   <= hi_key_c[MAX_ANCHORS] - lo_key_c[MAX_ANCHORS];
              olo   <= lo_oth_c[MAX_ANCHORS];
              neg   <= hi_oth_c[MAX_ANCHORS] < lo_oth_c[MAX_ANCHORS];
              mag   <= (hi_oth_c[MAX_ANCHORS] < lo_oth_c[MAX_ANCHORS])
                       ? lo_oth_c[MAX_ANCHORS] - hi_oth_c[MAX_ANCHORS]
                       : hi_oth_c[MAX_ANCHORS] - lo_oth_c[MAX_ANCHORS];
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod   <= (2*LINE_BITS)'(q_d) * (2*LINE_BITS)'(mag);
          div_go <= 1'b1;
          state  <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            mapped_pos <= neg ? olo - div_quo : olo + div_quo;
            done       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/atlm_cell.sv]
// One anchor cell: holds a pair and steps the lookup word to its neighbour
`timescale 1ns / 1ps
module atlm_cell
  import atlm_pkg::*;
#(
  parameter int LINE_BITS = LINE_BITS_DEF,
  parameter int CNT_W     = 7,
  parameter int IDX       = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 app_en,
  input  logic [CNT_W-1:0]     count,
  input  logic [LINE_BITS-1:0] new_left,
  input  logic [LINE_BITS-1:0] new_right,
  input  tok_ctl_t             ctl_in,
  input  logic [LINE_BITS-1:0] q_in,
  input  logic [LINE_BITS-1:0] lo_key_in,
  input  logic [LINE_BITS-1:0] lo_oth_in,
  input  logic [LINE_BITS-1:0] hi_key_in,
  input  logic [LINE_BITS-1:0] hi_oth_in,
  output tok_ctl_t             ctl_out,
  output logic [LINE_BITS-1:0] q_out,
  output logic [LINE_BITS-1:0] lo_key_out,
  output logic [LINE_BITS-1:0] lo_oth_out,
  output logic [LINE_BITS-1:0] hi_key_out,
  output logic [LINE_BITS-1:0] hi_oth_out
);

  localparam logic FIRST = (IDX == 0);

  logic [LINE_BITS-1:0] left_line;
  logic [LINE_BITS-1:0] right_line;
  logic [LINE_BITS-1:0] key;
  logic [LINE_BITS-1:0] oth;
  logic                 active;
  logic                 hit;
  tok_ctl_t             ctl_next;

  always_comb begin
    key    = ctl_in.dir ? left_line : right_line;
    oth    = ctl_in.dir ? right_line : left_line;
    active = ctl_in.valid && !ctl_in.found && (count > CNT_W'(IDX));
    hit    = active && (key >= q_in);
    ctl_next       = ctl_in;
    ctl_next.found = ctl_in.found || hit;
    ctl_next.pass  = ctl_in.pass || (hit && FIRST);
  end

  always_ff @(posedge clk) begin
    if (app_en && (count == CNT_W'(IDX))) begin
      left_line  <= new_left;
      right_line <= new_right;
    end
    q_out      <= q_in;
    lo_key_out <= (active && !hit) ? key : lo_key_in;
    lo_oth_out <= (active && !hit) ? oth : lo_oth_in;
    hi_key_out <= hit ? key : hi_key_in;
    hi_oth_out <= hit ? oth : hi_oth_in;
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_next;
    end
  end

endmodule

[rtl/atlm_div.sv]
// Restoring divider, one quotient bit per cycle, quotient known to fit LINE_BITS
`timescale 1ns / 1ps
module atlm_div #(
  parameter int LINE_BITS = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [2*LINE_BITS-1:0] num,
  input  logic [LINE_BITS-1:0]   den,
  output logic                   done,
  output logic [LINE_BITS-1:0]   quo
);

  localparam int STEP_W = $clog2(LINE_BITS + 1);

  logic                 running;
  logic [STEP_W-1:0]    steps;
  logic [LINE_BITS-1:0] rem;
  logic [LINE_BITS-1:0] low;
  logic [LINE_BITS:0]   trial;
  logic                 take;

  always_comb begin
    trial = {rem, low[LINE_BITS-1]};
    take  = (trial >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      steps   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        steps   <= STEP_W'(LINE_BITS);
        rem     <= num[2*LINE_BITS-1:LINE_BITS];
        low     <= num[LINE_BITS-1:0];
        quo     <= '0;
      end else if (running) begin
        rem   <= take ? LINE_BITS'(trial - {1'b0, den}) : trial[LINE_BITS-1:0];
        low   <= {low[LINE_BITS-2:0], 1'b0};
        quo   <= {quo[LINE_BITS-2:0], take};
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/atlm_checker.sv]
// Port-level checks for the anchor table line mapper, bound to the top level
`timescale 1ns / 1ps
`include "anchor_table_line_mapper_core_defines.svh"
module atlm_checker
  import atlm_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] action,
  input logic       done
);

  logic map_acc;
  logic upd_acc;

  assign map_acc = start && !busy && ((action_t'(action) == ACT_MAP_RL)
                                      || (action_t'(action) == ACT_MAP_LR));
  assign upd_acc = start && !busy && ((action_t'(action) == ACT_CLEAR)
                                      || (action_t'(action) == ACT_APPEND));

  `ATLM_ASSERT_NEXT(a_map_goes_busy, clk, rst, map_acc, busy && !done)
  `ATLM_ASSERT_NEXT(a_update_no_word, clk, rst, upd_acc, !busy && !done)
  `ATLM_ASSERT_IMPL(a_word_ends_busy, clk, rst, done, !busy && $past(busy))
  `ATLM_ASSERT_NEXT(a_single_word, clk, rst, done, !done)

endmodule

bind anchor_table_line_mapper_core atlm_checker u_atlm_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .action (action),
  .done   (done)
);

[tb/tb.sv]
// Testbench for anchor_table_line_mapper_core: directed and random words checked against a predictor
`timescale 1ns / 1ps
module tb;
  import atlm_pkg::*;

  localparam int NA          = MAX_ANCHORS_DEF;
  localparam int LB          = LINE_BITS_DEF;
  localparam int LMAX        = (1 << LB) - 1;
  localparam int WORD_TARGET = 1700;
  localparam int QUIET_LIMIT = 2000;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic          busy;
  logic [1:0]    action = ACT_CLEAR;
  logic [LB-1:0] left_line = '0;
  logic [LB-1:0] right_line = '0;
  logic [LB-1:0] query_pos = '0;
  logic          done;
  logic [LB-1:0] mapped_pos;

  // predictor state
  logic [LB-1:0] left_tbl [NA];
  logic [LB-1:0] right_tbl [NA];
  int            anchors = 0;
  logic [LB-1:0] expected_pos [$];

  int errors = 0;
  int words_sent = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  bit steady = 1'b1;
  bit start_up = 1'b0;

  anchor_table_line_mapper_core #(
    .MAX_ANCHORS(NA),
    .LINE_BITS  (LB)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .action    (action),
    .left_line (left_line),
    .right_line(right_line),
    .query_pos (query_pos),
    .done      (done),
    .mapped_pos(mapped_pos)
  );

  always #10 clk = ~clk;

  function automatic logic [LB-1:0] predict_mapped(bit from_left, logic [LB-1:0] q);
    logic [LB-1:0] keys [NA];
    logic [LB-1:0] others [NA];
    int k;
    longint num, den, res;
    for (int i = 0; i < NA; i++) begin
      keys[i]   = from_left ? left_tbl[i] : right_tbl[i];
      others[i] = from_left ? right_tbl[i] : left_tbl[i];
    end
    k = 0;
    while (k < anchors && keys[k] < q) k++;
    if (k == 0 || k >= anchors) return q;
    den = longint'(keys[k]) - longint'(keys[k-1]);
    num = (longint'(q) - longint'(keys[k-1])) *
          (longint'(others[k]) - longint'(others[k-1]));
    if (den <= 0) return q;
    res = longint'(others[k-1]) + num / den;
    if (res < 0) res = 0;
    return res[LB-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [LB-1:0] got, logic [LB-1:0] want);
    $display("mismatch at %0t: %s, got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic hold_off(int n);
    if (start_up) begin
      start <= 1'b0;
      start_up = 1'b0;
    end
    repeat (n) @(posedge clk);
  endtask

  task automatic pace();
    int gap;
    if (steady) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 16);
    gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 100) : $urandom_range(1, 6);
    hold_off(gap);
  endtask

  // sends one word, then updates the predicted table or queues the expected position
  task automatic send_word(action_t act, logic [LB-1:0] l, logic [LB-1:0] r,
                           logic [LB-1:0] q);
    action     <= act;
    left_line  <= l;
    right_line <= r;
    query_pos  <= q;
    start      <= 1'b1;
    start_up   = 1'b1;
    do @(posedge clk); while (busy);
    words_sent++;
    case (act)
      ACT_CLEAR: anchors = 0;
      ACT_APPEND: begin
        if (anchors < NA) begin
          left_tbl[anchors]  = l;
          right_tbl[anchors] = r;
          anchors++;
        end
      end
      ACT_MAP_RL: expected_pos.push_back(predict_mapped(1'b0, q));
      default:    expected_pos.push_back(predict_mapped(1'b1, q));
    endcase
    pace();
  endtask

  task automatic drain();
    hold_off(0);
    while (expected_pos.size() != 0) @(posedge clk);
  endtask

  function automatic logic [LB-1:0] pick_query(bit from_left);
    int sel, k;
    logic [LB-1:0] base, nxt, lo, hi;
    sel = $urandom_range(0, 9);
    if (anchors == 0 || sel == 0) return LB'($urandom_range(0, LMAX));
    if (sel == 1) return '0;
    if (sel == 2) return LB'(LMAX);
    k    = $urandom_range(0, anchors - 1);
    base = from_left ? left_tbl[k] : right_tbl[k];
    case (sel)
      3: return base;
      4: return base + 1'b1;
      5: return base - 1'b1;
      default: begin
        if (k + 1 >= anchors) return base + LB'($urandom_range(0, 1000));
        nxt = from_left ? left_tbl[k+1] : right_tbl[k+1];
        lo  = (nxt < base) ? nxt : base;
        hi  = (nxt < base) ? base : nxt;
        return lo + LB'($urandom_range(0, hi - lo));
      end
    endcase
  endfunction

  // style 0: both sides rising, 1: right side falling, 2: arbitrary values
  task automatic build_table(int n, int style);
    int span;
    logic [LB-1:0] l, r;
    span = LMAX / (n + 1);
    l = LB'($urandom_range(0, span));
    r = LB'($urandom_range(0, span));
    for (int i = 0; i < n; i++) begin
      if (style == 2) begin
        send_word(ACT_APPEND, LB'($urandom_range(0, LMAX)), LB'($urandom_range(0, LMAX)),
                  LB'($urandom_range(0, LMAX)));
      end else begin
        send_word(ACT_APPEND, l, (style == 1) ? LB'(LMAX) - r : r,
                  LB'($urandom_range(0, LMAX)));
        l = l + LB'($urandom_range((i % 7 == 6) ? 0 : 1, span));
        r = r + LB'($urandom_range(0, span));
      end
    end
  endtask

  task automatic send_map();
    bit from_left;
    from_left = $urandom_range(0, 1);
    send_word(from_left ? ACT_MAP_LR : ACT_MAP_RL, LB'($urandom_range(0, LMAX)),
              LB'($urandom_range(0, LMAX)), pick_query(from_left));
  endtask

  task automatic test_empty_table();
    send_word(ACT_CLEAR, LB'(LMAX), LB'(LMAX), LB'(LMAX));
    send_word(ACT_MAP_RL, '0, '0, '0);
    send_word(ACT_MAP_LR, '0, '0, LB'(LMAX));
    drain();
  endtask

  task automatic test_edge_anchors();
    steady = 1'b0;
    send_word(ACT_CLEAR, '0, '0, '0);
    send_word(ACT_APPEND, 20'd100, 20'd1000, '0);
    send_word(ACT_APPEND, 20'd200, 20'd3, LB'(LMAX));
    send_word(ACT_APPEND, 20'd5000, LB'(LMAX), '0);
    send_word(ACT_APPEND, 20'hFFFFE, 20'd40, '0);
    send_word(ACT_MAP_LR, '0, '0, 20'd50);
    send_word(ACT_MAP_LR, '0, '0, 20'd100);
    send_word(ACT_MAP_LR, '0, '0, 20'd101);
    send_word(ACT_MAP_LR, '0, '0, 20'd199);
    send_word(ACT_MAP_LR, LB'(LMAX), LB'(LMAX), 20'hFFFFE);
    send_word(ACT_MAP_LR, '0, '0, LB'(LMAX));
    send_word(ACT_MAP_RL, '0, '0, '0);
    send_word(ACT_MAP_RL, '0, '0, 20'd2);
    send_word(ACT_MAP_RL, '0, '0, 20'd500);
    send_word(ACT_MAP_RL, '0, '0, LB'(LMAX));
    drain();
  endtask

  // two appends past the limit must be dropped
  task automatic test_full_table();
    logic [LB-1:0] last_left;
    steady = 1'b1;
    send_word(ACT_CLEAR, '0, '0, '0);
    for (int i = 0; i < NA + 2; i++) begin
      last_left = LB'(i * 1000 + 7);
      send_word(ACT_APPEND, last_left, LB'(LMAX - i * 333), LB'($urandom_range(0, LMAX)));
    end
    send_word(ACT_MAP_LR, '0, '0, last_left);
    send_word(ACT_MAP_LR, '0, '0, LB'((NA - 1) * 1000 + 6));
    send_word(ACT_MAP_LR, '0, '0, LB'((NA - 2) * 1000 + 500));
    send_word(ACT_MAP_RL, '0, '0, LB'(LMAX - 100));
    drain();
  endtask

  task automatic test_random_sequences();
    int sel, n, maps;
    while (words_sent < WORD_TARGET) begin
      steady = ($urandom_range(0, 9) < 3);
      sel = $urandom_range(0, 19);
      if (sel < 16)      n = $urandom_range(0, 8);
      else if (sel < 19) n = $urandom_range(9, 40);
      else               n = $urandom_range(60, 70);
      if ($urandom_range(0, 9) != 0)
        send_word(ACT_CLEAR, LB'($urandom_range(0, LMAX)), LB'($urandom_range(0, LMAX)),
                  LB'($urandom_range(0, LMAX)));
      build_table(n, $urandom_range(0, 4) == 0 ? 2 : $urandom_range(0, 1));
      maps = $urandom_range(2, 12);
      repeat (maps) begin
        if ($urandom_range(0, 9) == 0)
          send_word(action_t'($urandom_range(0, 3)), LB'($urandom_range(0, LMAX)),
                    LB'($urandom_range(0, LMAX)), LB'($urandom_range(0, LMAX)));
        else
          send_map();
      end
      if ($urandom_range(0, 15) == 0) drain();
    end
    drain();
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_pos.size() == 0)
        report_mismatch("result with none pending", mapped_pos, '0);
      else if (mapped_pos !== expected_pos[0])
        report_mismatch("mapped_pos", mapped_pos, expected_pos.pop_front());
      else
        void'(expected_pos.pop_front());
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_edge_anchors();
    test_full_table();
    test_random_sequences();
    repeat (NA + LB + 8) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
